// ----- hw/rtl/mti_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mti_pkg
// types, codes and defaults shared by the table interpolator
// ----------------------------------------------------------------------------
package mti_pkg;

   localparam int unsigned TableDepthDefault = 32768;
   localparam int unsigned FracBitsDefault   = 16;

   localparam logic [1:0] OP_LOAD      = 2'd0;
   localparam logic [1:0] OP_DIST_TO_Z = 2'd1;
   localparam logic [1:0] OP_Z_TO_DIST = 2'd2;
   localparam logic [1:0] OP_UNUSED    = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_ZERO  = 2'd2;

   localparam logic CSR_TABLE_ENTRIES  = 1'b0;
   localparam logic CSR_REDSHIFT_LIMIT = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SEARCH,
      S_SWAIT,
      S_SCMP,
      S_RD0,
      S_RD1,
      S_RWAIT,
      S_PREP,
      S_MUL,
      S_DIV,
      S_DONE,
      S_OUT
   } state_type;

endpackage
`default_nettype wire

// ----- hw/rtl/monotone_table_interpolator.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// monotone_table_interpolator
// paired ascending tables with binary search and linear interpolation
//
//  channel | direction | handshake       | payload
//  req     | in        | valid / stall   | opcode, entry_index, redshift_in, distance_in
//  rsp     | out       | valid / stall   | value_out, status
//  csr     | in        | valid / ready   | index, data
//
// a load writes both tables and goes straight to its response; a query runs
// s = log2(entries)+1 search steps, each a read, a wait and a compare, and
// then a restoring divide of one bit per cycle over the 64-bit product
// through a single subtractor
// synchronous reset clears the sequencer and rsp valid and sets the csr registers to their defaults only
// rsp holds its value while stalled; req is stalled for the whole item
// ----------------------------------------------------------------------------
module monotone_table_interpolator #(
   parameter int unsigned TABLE_DEPTH = mti_pkg::TableDepthDefault,
   parameter int unsigned FRAC_BITS   = mti_pkg::FracBitsDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_opcode,
   input  wire logic [14:0] req_entry_index,
   input  wire logic [31:0] req_redshift_in,
   input  wire logic [31:0] req_distance_in,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_value_out,
   output logic [1:0]       rsp_status,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [31:0] csr_data
);
   import mti_pkg::*;

   localparam int unsigned AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int unsigned NW  = $clog2(TABLE_DEPTH + 1);
   localparam int unsigned DCW = 6;

   // tables
   logic [31:0] zmem [TABLE_DEPTH];
   logic [31:0] dmem [TABLE_DEPTH];
   logic [31:0] zrd_ff, drd_ff;
   logic        we;
   logic [AW-1:0] waddr, raddr;

   always_ff @(posedge clock) begin
      if (we) begin
         zmem[waddr] <= req_redshift_in;
         dmem[waddr] <= req_distance_in;
      end
      zrd_ff <= zmem[raddr];
      drd_ff <= dmem[raddr];
   end

   // registers
   state_type     state_ff, state_in;
   logic [15:0]   entries_ff;
   logic [31:0]   limit_ff;
   logic          dir_ff, dir_in;       // 1: key in distance table
   logic [31:0]   key_ff, key_in;
   logic [NW-1:0] lo_ff, lo_in, hi_ff, hi_in, n_ff, n_in;
   logic [31:0]   x0_ff, x0_in, y0_ff, y0_in, x1_ff, x1_in, y1_ff, y1_in;
   logic          neg_ff, neg_in;
   logic [63:0]   rem_ff, rem_in;       // dividend, shifted out into the partial remainder
   logic [31:0]   span_ff, span_in;
   logic [31:0]   quo_ff, quo_in;
   logic [31:0]   part_ff, part_in;
   logic [DCW-1:0] cnt_ff, cnt_in;
   logic          rv_ff, rv_in;
   logic [31:0]   val_ff, val_in;
   logic [1:0]    st_ff, st_in;

   logic [NW-1:0] mid;
   logic [31:0]   xrd, yrd;
   logic [32:0]   trial;
   logic [63:0]   prod;
   logic [15:0]   n_clamp;

   assign mid = NW'((({1'b0, lo_ff}) + ({1'b0, hi_ff})) >> 1);
   assign xrd = dir_ff ? drd_ff : zrd_ff;
   assign yrd = dir_ff ? zrd_ff : drd_ff;
   assign trial = {part_ff, rem_ff[63]} - {1'b0, span_ff};
   assign prod  = 64'(x1_ff) * 64'(y1_ff);

   always_comb begin
      n_clamp = entries_ff;
      if (n_clamp < 16'd2) n_clamp = 16'd2;
      if (32'(n_clamp) > TABLE_DEPTH) n_clamp = 16'(TABLE_DEPTH);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         entries_ff <= 16'd2;
         limit_ff   <= 32'(9) << FRAC_BITS;
         rv_ff      <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_TABLE_ENTRIES:  entries_ff <= csr_data[15:0];
               CSR_REDSHIFT_LIMIT: limit_ff   <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      dir_ff <= dir_in; key_ff <= key_in; lo_ff <= lo_in; hi_ff <= hi_in;
      n_ff <= n_in; x0_ff <= x0_in; y0_ff <= y0_in; x1_ff <= x1_in;
      y1_ff <= y1_in; neg_ff <= neg_in; rem_ff <= rem_in; span_ff <= span_in;
      quo_ff <= quo_in; part_ff <= part_in; cnt_ff <= cnt_in;
      val_ff <= val_in; st_ff <= st_in;
   end

   always_comb begin
      state_in = state_ff;
      dir_in = dir_ff; key_in = key_ff; lo_in = lo_ff; hi_in = hi_ff;
      n_in = n_ff; x0_in = x0_ff; y0_in = y0_ff; x1_in = x1_ff; y1_in = y1_ff;
      neg_in = neg_ff; rem_in = rem_ff; span_in = span_ff; quo_in = quo_ff;
      part_in = part_ff; cnt_in = cnt_ff; rv_in = rv_ff;
      val_in = val_ff; st_in = st_ff;
      we = 1'b0;
      waddr = req_entry_index[AW-1:0];
      raddr = mid[AW-1:0];
      req_stall = 1'b1;
      csr_ready = (state_ff == S_IDLE) && !rv_ff;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = rv_ff;
            if (req_valid && !rv_ff) begin
               val_in = '0;
               st_in  = ST_OK;
               n_in   = NW'(n_clamp);
               lo_in  = '0;
               hi_in  = NW'(n_clamp);
               state_in = S_OUT;
               unique case (req_opcode)
                  OP_LOAD: begin
                     we = (32'(req_entry_index) < TABLE_DEPTH);
                  end
                  OP_DIST_TO_Z: begin
                     dir_in = 1'b1;
                     key_in = req_distance_in;
                     state_in = S_SEARCH;
                  end
                  OP_Z_TO_DIST: begin
                     dir_in = 1'b0;
                     key_in = req_redshift_in[31] ? 32'd0 : req_redshift_in;
                     if ((req_redshift_in[31] ? 32'd0 : req_redshift_in) >= limit_ff)
                        st_in = ST_RANGE;
                     else
                        state_in = S_SEARCH;
                  end
                  default: ;
               endcase
            end
         end
         S_SEARCH: begin
            if (lo_ff < hi_ff) state_in = S_SWAIT;
            else if (lo_ff == '0 || lo_ff >= n_ff) begin
               st_in = ST_RANGE;
               state_in = S_OUT;
            end else state_in = S_RD0;
         end
         S_SWAIT: state_in = S_SCMP;
         S_SCMP: begin
            if (xrd > key_ff) hi_in = mid;
            else lo_in = mid + NW'(1);
            state_in = S_SEARCH;
         end
         S_RD0: begin
            raddr = AW'(lo_ff - NW'(1));
            state_in = S_RD1;
         end
         S_RD1: begin
            raddr = lo_ff[AW-1:0];
            x0_in = xrd;
            y0_in = yrd;
            state_in = S_RWAIT;
         end
         S_RWAIT: begin
            x1_in = xrd;
            y1_in = yrd;
            state_in = S_PREP;
         end
         S_PREP: begin
            if (x1_ff <= x0_ff) begin
               st_in = ST_ZERO;
               state_in = S_OUT;
            end else begin
               span_in = x1_ff - x0_ff;
               x1_in   = key_ff - x0_ff;
               neg_in  = y1_ff < y0_ff;
               y1_in   = (y1_ff < y0_ff) ? y0_ff - y1_ff : y1_ff - y0_ff;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            rem_in  = prod;
            part_in = '0;
            quo_in  = '0;
            cnt_in  = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            // one restoring step per cycle over 64 dividend bits; quotient fits 32
            rem_in = {rem_ff[62:0], 1'b0};
            if (!trial[32]) begin
               part_in = trial[31:0];
               quo_in  = {quo_ff[30:0], 1'b1};
            end else begin
               part_in = {part_ff[30:0], rem_ff[63]};
               quo_in  = {quo_ff[30:0], 1'b0};
            end
            cnt_in = cnt_ff + DCW'(1);
            if (cnt_ff == '1) state_in = S_DONE;
         end
         S_DONE: begin
            val_in = neg_ff ? y0_ff - quo_ff : y0_ff + quo_ff;
            state_in = S_OUT;
         end
         S_OUT: begin
            rv_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      if (rv_ff && !rsp_stall) rv_in = 1'b0;
   end

   assign rsp_valid     = rv_ff;
   assign rsp_value_out = val_ff;
   assign rsp_status    = st_ff;

`ifndef ASSERT_OFF
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> req_stall) else $error("accept while busy");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> (rsp_value_out == 32'd0))
      else $error("error result not zero");
   a_csr_idle: assert property (@(posedge clock) disable iff (reset)
      csr_ready |-> (state_ff == S_IDLE && !rv_ff)) else $error("csr while busy");
   a_search_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEARCH) |-> (lo_ff <= hi_ff && hi_ff <= n_ff))
      else $error("search bounds");
`endif

endmodule
`default_nettype wire

// ----- tb/sv/mti_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mti_checker
// watches the request, response and csr channels, predicts each response of
// the table interpolator from its own copy of the tables and registers, and
// compares every response field by field in order
// ----------------------------------------------------------------------------
module mti_checker
   import mti_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [1:0]  req_opcode,
   input  wire logic [14:0] req_entry_index,
   input  wire logic [31:0] req_redshift_in,
   input  wire logic [31:0] req_distance_in,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic [31:0] rsp_value_out,
   input  wire logic [1:0]  rsp_status,
   input  wire logic        csr_valid,
   input  wire logic        csr_ready,
   input  wire logic        csr_index,
   input  wire logic [31:0] csr_data,
   output int               fail_count,
   output int               pending_count
);

   localparam int unsigned Depth = TableDepthDefault;

   typedef struct packed {
      logic [31:0] value;
      logic [1:0]  status;
   } answer_t;

   logic [31:0] z_table [Depth];
   logic [31:0] d_table [Depth];
   logic [15:0] entries_reg;
   logic [31:0] zlimit_reg;
   answer_t     answer_queue [$];

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
      fail_count++;
   endtask

   function automatic answer_t lookup(input logic [31:0] key, input bit z_keyed);
      answer_t     a;
      int unsigned n, lo, hi, mid;
      logic [31:0] x0, x1, y0, y1, kx;
      logic [63:0] q;
      a = '0;
      n = entries_reg < 2 ? 2 : entries_reg;
      if (n > Depth) n = Depth;
      lo = 0;
      hi = n;
      while (lo < hi) begin
         mid = (lo + hi) / 2;
         kx = z_keyed ? z_table[mid] : d_table[mid];
         if (kx > key) hi = mid;
         else lo = mid + 1;
      end
      if (lo == 0 || lo >= n) begin
         a.status = ST_RANGE;
         return a;
      end
      x0 = z_keyed ? z_table[lo-1] : d_table[lo-1];
      x1 = z_keyed ? z_table[lo]   : d_table[lo];
      y0 = z_keyed ? d_table[lo-1] : z_table[lo-1];
      y1 = z_keyed ? d_table[lo]   : z_table[lo];
      if (x1 <= x0) begin
         a.status = ST_ZERO;
         return a;
      end
      if (y1 >= y0) begin
         q = (64'(key - x0) * 64'(y1 - y0)) / 64'(x1 - x0);
         a.value = y0 + q[31:0];
      end else begin
         q = (64'(key - x0) * 64'(y0 - y1)) / 64'(x1 - x0);
         a.value = y0 - q[31:0];
      end
      a.status = ST_OK;
      return a;
   endfunction

   always @(posedge clock) begin
      answer_t     a, want;
      logic [31:0] z;
      if (reset) begin
         entries_reg <= 16'd2;
         zlimit_reg  <= 32'd9 << FracBitsDefault;
         answer_queue.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_TABLE_ENTRIES) entries_reg <= csr_data[15:0];
            else zlimit_reg <= csr_data;
         end
         if (req_valid && !req_stall) begin
            a = '0;
            case (req_opcode)
               OP_LOAD: begin
                  z_table[req_entry_index] = req_redshift_in;
                  d_table[req_entry_index] = req_distance_in;
               end
               OP_DIST_TO_Z: a = lookup(req_distance_in, 1'b0);
               OP_Z_TO_DIST: begin
                  z = req_redshift_in[31] ? 32'd0 : req_redshift_in;
                  if (z >= zlimit_reg) a.status = ST_RANGE;
                  else a = lookup(z, 1'b1);
               end
               default: ;
            endcase
            if (a.status != ST_OK) a.value = '0;
            answer_queue.push_back(a);
         end
         if (rsp_valid && !rsp_stall) begin
            if (answer_queue.size() == 0) begin
               report_mismatch("unexpected transfer", rsp_value_out, 0);
            end else begin
               want = answer_queue.pop_front();
               if (rsp_value_out !== want.value)
                  report_mismatch("value_out", rsp_value_out, want.value);
               if (rsp_status !== want.status)
                  report_mismatch("status", 32'(rsp_status), 32'(want.status));
            end
         end
      end
      pending_count = answer_queue.size();
   end

   initial fail_count = 0;

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// drives loads and queries into the table interpolator across several table
// sizes and limits, with random gaps and stalls; a checker predicts results
// ----------------------------------------------------------------------------
module tb;
   import mti_pkg::*;

   localparam int NumRandom = 720;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_opcode = '0;
   logic [14:0] req_entry_index = '0;
   logic [31:0] req_redshift_in = '0;
   logic [31:0] req_distance_in = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_value_out;
   logic [1:0]  rsp_status;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = 1'b0;
   logic [31:0] csr_data = '0;
   int          fail_count;
   int          pending_count;
   int          gap_pct = 34;
   bit          hold_off = 1'b0;
   logic [31:0] z_loaded [TableDepthDefault];
   logic [31:0] d_loaded [TableDepthDefault];
   int          entries_now;

   always #6 clock = ~clock;

   monotone_table_interpolator u_dut (.*);

   mti_checker u_checker (.*);

   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else if (hold_off) rsp_stall <= 1'b1;
      else rsp_stall <= ($urandom_range(99) < gap_pct);
   end

   task automatic send(input logic [1:0] op, input logic [14:0] idx,
                       input logic [31:0] z, input logic [31:0] d);
      @(posedge clock);
      while ($urandom_range(99) < gap_pct) @(posedge clock);
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_entry_index <= idx;
      req_redshift_in <= z;
      req_distance_in <= d;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      req_valid <= 1'b0;
      if (op == OP_LOAD) begin
         z_loaded[idx] = z;
         d_loaded[idx] = d;
      end
   endtask

   task automatic write_csr(input logic idx, input logic [31:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_TABLE_ENTRIES) entries_now = data[15:0] < 2 ? 2 : data[15:0];
   endtask

   task automatic drain();
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   // ascending table of n entries; mostly increasing distance, some descending
   task automatic load_table(input int n, input bit flat_z);
      logic [31:0] z, d;
      bit          down;
      z = $urandom_range(1000);
      d = $urandom_range(1000);
      down = ($urandom_range(3) == 0);
      if (down) d = 32'hF000_0000;
      for (int i = 0; i < n; i++) begin
         send(OP_LOAD, 15'(i), z, d);
         z += (flat_z && i == 1) ? 0 : $urandom_range(1, 40000);
         if (down) d -= $urandom_range(0, 70000);
         else d += $urandom_range(0, 70000);
      end
   endtask

   function automatic logic [31:0] near(input logic [31:0] a);
      return a + $urandom_range(0, 8) - 4;
   endfunction

   task automatic random_query();
      int          k;
      logic [31:0] z, d;
      k = $urandom_range(entries_now - 1);
      z = $urandom_range(4) == 0 ? $urandom : near(z_loaded[k]);
      d = $urandom_range(4) == 0 ? $urandom : near(d_loaded[k]);
      send(2'($urandom_range(1, 2)), 15'($urandom), z, d);
   endtask

   initial begin
      int n;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      entries_now = 2;
      @(posedge clock);
      // directed: edges of fields, unused opcode, negative key, limit
      send(OP_LOAD, 15'd0, 32'd0, 32'd0);
      send(OP_LOAD, 15'd1, 32'h0004_0000, 32'hFFFF_FFFF);
      send(OP_LOAD, 15'h7FFF, 32'h8000_0000, 32'hFFFF_FFFF);
      send(OP_Z_TO_DIST, 15'h7FFF, 32'h0001_8000, 32'd0);
      send(OP_Z_TO_DIST, 15'd0, 32'hFFFF_FFFF, 32'd0);
      send(OP_Z_TO_DIST, 15'd0, 32'h8000_0000, 32'd0);
      send(OP_Z_TO_DIST, 15'd0, 32'h0009_0000, 32'd0);
      send(OP_Z_TO_DIST, 15'd0, 32'h0004_0000, 32'd0);
      send(OP_Z_TO_DIST, 15'd0, 32'h7FFF_FFFF, 32'd0);
      send(OP_DIST_TO_Z, 15'd0, 32'd0, 32'h8000_0000);
      send(OP_DIST_TO_Z, 15'd0, 32'd0, 32'hFFFF_FFFF);
      send(OP_DIST_TO_Z, 15'd0, 32'd0, 32'd0);
      send(OP_UNUSED, 15'h7FFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send(OP_LOAD, 15'd1, 32'd0, 32'h0001_0000);
      send(OP_DIST_TO_Z, 15'd0, 32'd0, 32'h0000_8000);
      send(OP_Z_TO_DIST, 15'd0, 32'd0, 32'd0);
      drain();
      write_csr(CSR_REDSHIFT_LIMIT, 32'd0);
      send(OP_Z_TO_DIST, 15'd0, 32'd0, 32'd0);
      drain();
      write_csr(CSR_REDSHIFT_LIMIT, 32'hFFFF_FFFF);
      write_csr(CSR_TABLE_ENTRIES, 32'd0);
      send(OP_Z_TO_DIST, 15'd0, 32'h0000_1000, 32'd0);
      drain();
      // phases over table sizes; the last one with a large table
      for (int phase = 0; phase < 6; phase++) begin
         n = (phase == 5) ? 600 : (phase == 0 ? 2 : $urandom_range(3, 40));
         write_csr(CSR_TABLE_ENTRIES, phase == 4 ? 32'hFFFF_0003 : 32'(n));
         if (phase == 4) n = 3;
         write_csr(CSR_REDSHIFT_LIMIT,
                   phase % 2 ? 32'hFFFF_FFFF : 32'($urandom_range(20000, 600000)));
         load_table(n, phase == 2);
         gap_pct = (phase == 3) ? 0 : 34;
         for (int i = 0; i < NumRandom / 6; i++) begin
            if ($urandom_range(19) == 0) send(OP_UNUSED, 15'($urandom), $urandom, $urandom);
            else random_query();
         end
         if (phase == 1) begin
            hold_off = 1'b1;
            fork
               begin
                  repeat (400) @(posedge clock);
                  hold_off = 1'b0;
               end
               repeat (3) random_query();
            join
         end
         drain();
      end
      // table size register at full depth, then a grown table
      write_csr(CSR_TABLE_ENTRIES, 32'd32768);
      for (int i = 600; i < 640; i++) begin
         send(OP_LOAD, 15'(i), 32'h7000_0000 + 32'(i), 32'(i) << 8);
      end
      drain();
      write_csr(CSR_TABLE_ENTRIES, 32'd640);
      repeat (10) random_query();
      drain();
      if (fail_count == 0 && pending_count == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

   initial begin
      #60ms;
      $display("Test completed with failures");
      $finish;
   end

endmodule
